@@ rtl/bffpa_pkg.sv @@
// Package: shared types, codes and defaults of the bitmap page allocator.
`timescale 1ns / 1ps
package bffpa_pkg;

    localparam int MAX_PAGES_DEF  = 8192;
    localparam int PAGE_SHIFT_DEF = 21;

    localparam logic [1:0] ST_ALLOC   = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_FREED   = 2'd2;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef struct packed {
        logic        action;
        logic [34:0] size_bytes;
        logic [47:0] free_address;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [47:0] result_address;
    } t_out_item;

    typedef struct packed {
        logic init_step;
        logic load;
        logic chk;
        logic scan_rd;
        logic eval;
        logic scan_to_mark;
        logic mark_step;
        logic clr_step;
        logic emit_alloc;
        logic emit_fail;
        logic emit_free;
    } t_cmd;

    typedef struct packed {
        logic init_last;
        logic end_over;
        logic cur_lt_end;
        logic found;
        logic mark_more;
        logic clr_more;
        logic out_busy;
    } t_stat;

endpackage

@@ rtl/bffpa_ctrl.sv @@
// Controller: sequences reset clearing, allocate scan, marking and freeing.
`timescale 1ns / 1ps
module bffpa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_free,
    input  bffpa_pkg::t_stat i_stat,
    output bffpa_pkg::t_cmd  o_cmd,
    output logic             o_in_stall
);
    import bffpa_pkg::*;

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_EVAL = 3'd4;
    localparam logic [2:0] S_MARK = 3'd5;
    localparam logic [2:0] S_FREE = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Take an item only when idle and the output register is free
    assign o_in_stall = (r_state != S_IDLE) || i_stat.out_busy;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                o_cmd.init_step = 1'b1;
                if (i_stat.init_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid && !i_stat.out_busy) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_in_free ? S_FREE : S_CHK;
                end
            end
            S_CHK: begin
                if (i_stat.end_over) begin
                    o_cmd.emit_fail = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.chk = 1'b1;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.cur_lt_end) begin
                    o_cmd.scan_rd = 1'b1;
                    n_state       = S_EVAL;
                end else if (i_stat.found) begin
                    o_cmd.scan_to_mark = 1'b1;
                    n_state            = S_MARK;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_SCAN;
            end
            S_MARK: begin
                if (i_stat.mark_more) begin
                    o_cmd.mark_step = 1'b1;
                end else begin
                    o_cmd.emit_alloc = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_FREE: begin
                if (i_stat.clr_more) begin
                    o_cmd.clr_step = 1'b1;
                end else begin
                    o_cmd.emit_free = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_INIT;
        else          r_state <= n_state;
    end

endmodule

@@ rtl/bffpa_datapath.sv @@
// Datapath: page bitmap memory, scan pointers, hint and result register.
`timescale 1ns / 1ps
module bffpa_datapath #(
    parameter int MAX_PAGES  = bffpa_pkg::MAX_PAGES_DEF,
    parameter int PAGE_SHIFT = bffpa_pkg::PAGE_SHIFT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bffpa_pkg::t_cmd      i_cmd,
    input  bffpa_pkg::t_in_item  i_in_item,
    input  logic [47:0]          i_pool_base,
    input  logic [13:0]          i_pool_pages,
    input  logic                 i_out_stall,
    output bffpa_pkg::t_stat     o_stat,
    output logic                 o_out_valid,
    output bffpa_pkg::t_out_item o_out_item
);
    import bffpa_pkg::*;

    localparam int AW  = $clog2(MAX_PAGES);
    localparam int PW  = $clog2(MAX_PAGES + 1);
    localparam int NW  = 36 - PAGE_SHIFT;
    localparam int EW  = ((PW > NW) ? PW : NW) + 1;
    localparam int FBW = 48 - PAGE_SHIFT;
    localparam logic [35:0] PAGE_M1 = 36'((64'd1 << PAGE_SHIFT) - 64'd1);
    localparam logic [63:0] MAX64   = 64'(MAX_PAGES);

    logic mem [MAX_PAGES];
    logic r_rdata;

    logic [NW-1:0]  r_need;
    logic [EW-1:0]  r_beg;
    logic [EW-1:0]  r_cur;
    logic [EW-1:0]  r_end;
    logic [PW-1:0]  r_i;
    logic [PW-1:0]  r_lim;
    logic [PW-1:0]  r_hint;
    logic [FBW-1:0] r_fbeg;
    logic           r_found;
    logic           r_ovalid;
    t_out_item      r_oitem;

    logic [35:0]    w_sum;
    logic [NW-1:0]  w_need;
    logic [47:0]    w_off;
    logic [FBW-1:0] w_fbeg;
    logic [63:0]    w_fend64;
    logic [63:0]    w_total64;
    logic [EW-1:0]  w_end;
    logic [63:0]    w_hint64;
    logic [47:0]    w_addr;

    // Round the size up to pages, locate the first page of a free
    assign w_sum    = {1'b0, i_in_item.size_bytes} + PAGE_M1;
    assign w_need   = w_sum[35:PAGE_SHIFT];
    assign w_off    = i_in_item.free_address - i_pool_base;
    assign w_fbeg   = w_off[47:PAGE_SHIFT];
    assign w_fend64 = 64'(w_fbeg) + 64'(w_need);

    assign w_total64 = (64'(i_pool_pages) > MAX64) ? MAX64 : 64'(i_pool_pages);
    assign w_end     = r_beg + EW'(r_need);
    assign w_hint64  = 64'(r_hint);
    assign w_addr    = i_pool_base + 48'(64'(r_beg) << PAGE_SHIFT);

    assign o_stat.init_last  = (64'(r_i) == MAX64 - 64'd1);
    assign o_stat.end_over   = (64'(w_end) > w_total64);
    assign o_stat.cur_lt_end = (r_cur < r_end);
    assign o_stat.found      = r_found;
    assign o_stat.mark_more  = (64'(r_i) < 64'(r_end));
    assign o_stat.clr_more   = (r_i < r_lim);
    assign o_stat.out_busy   = r_ovalid && i_out_stall;

    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_oitem;

    // Write one bitmap bit per cycle; read the bit under the scan pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.init_step || i_cmd.clr_step) mem[r_i[AW-1:0]] <= 1'b0;
        else if (i_cmd.mark_step)              mem[r_i[AW-1:0]] <= 1'b1;
        if (i_cmd.scan_rd) r_rdata <= mem[r_cur[AW-1:0]];
    end

    // Scan pointers and page counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0;
        end else if (i_cmd.load) begin
            r_i <= (64'(w_fbeg) < MAX64) ? PW'(w_fbeg) : PW'(MAX_PAGES);
        end else if (i_cmd.scan_to_mark) begin
            r_i <= PW'(r_beg);
        end else if (i_cmd.init_step || i_cmd.mark_step || i_cmd.clr_step) begin
            r_i <= r_i + PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_need  <= w_need;
            r_beg   <= EW'(r_hint);
            r_cur   <= EW'(r_hint);
            r_fbeg  <= w_fbeg;
            r_lim   <= (w_fend64 < MAX64) ? PW'(w_fend64) : PW'(MAX_PAGES);
            r_found <= 1'b1;
        end
        if (i_cmd.chk) begin
            r_end   <= w_end;
            r_found <= 1'b1;
        end
        // Restart the run past a used page
        if (i_cmd.eval) begin
            if (r_rdata) begin
                r_beg   <= r_cur + EW'(1);
                r_found <= 1'b0;
            end
            r_cur <= r_cur + EW'(1);
        end
    end

    // Search hint
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hint <= '0;
        end else if (i_cmd.eval && r_rdata && (w_hint64 == 64'(r_cur))) begin
            r_hint <= r_hint + PW'(1);
        end else if (i_cmd.emit_alloc && (w_hint64 == 64'(r_beg))) begin
            r_hint <= PW'(r_end);
        end else if (i_cmd.emit_free && (64'(r_fbeg) < w_hint64)) begin
            r_hint <= PW'(r_fbeg);
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit_alloc || i_cmd.emit_fail || i_cmd.emit_free) begin
            r_ovalid <= 1'b1;
        end else if (r_ovalid && !i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_alloc) begin
            r_oitem.status         <= ST_ALLOC;
            r_oitem.result_address <= w_addr;
        end else if (i_cmd.emit_fail) begin
            r_oitem.status         <= ST_NOSPACE;
            r_oitem.result_address <= '0;
        end else if (i_cmd.emit_free) begin
            r_oitem.status         <= ST_FREED;
            r_oitem.result_address <= '0;
        end
    end

endmodule

@@ rtl/bitmap_first_fit_page_allocator_unit.sv @@
// Top level: configuration registers and controller/datapath of the page allocator.
`timescale 1ns / 1ps
// Page allocator over one pool kept as a bitmap of 2^PAGE_SHIFT-byte pages. After
// reset the bitmap is cleared by a pass over all MAX_PAGES pages during which no
// item is taken. An allocate item scans first-fit from the search hint, reading
// each page's bit (single-port bitmap read) and then evaluating it; each restart
// of the run passes through the scan exit and the end check again. It then sets
// the found run at one page per cycle. A free item clears one page per cycle
// inside the map. Results leave through a registered output; the next item is
// taken once the previous one is finished and its result slot is free.
module bitmap_first_fit_page_allocator_unit #(
    parameter int MAX_PAGES  = bffpa_pkg::MAX_PAGES_DEF,
    parameter int PAGE_SHIFT = bffpa_pkg::PAGE_SHIFT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  bffpa_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output bffpa_pkg::t_out_item o_out_item,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready
);
    import bffpa_pkg::*;

    logic [47:0] r_pool_base;
    logic [13:0] r_pool_pages;
    t_cmd        w_cmd;
    t_stat       w_stat;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign prdata = paddr[3] ? {50'd0, r_pool_pages} : {16'd0, r_pool_base};

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base  <= '0;
            r_pool_pages <= '0;
        end else if (w_wr) begin
            if (paddr[3]) r_pool_pages <= pwdata[13:0];
            else          r_pool_base  <= pwdata[47:0];
        end
    end

    bffpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_free  (i_in_item.action == ACT_FREE),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    bffpa_datapath #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_in_item    (i_in_item),
        .i_pool_base  (r_pool_base),
        .i_pool_pages (r_pool_pages),
        .i_out_stall  (i_out_stall),
        .o_stat       (w_stat),
        .o_out_valid  (o_out_valid),
        .o_out_item   (o_out_item)
    );

endmodule
